// ===== rtl/core/bucket_priority_queue_core_defines.svh =====
// ---------------------------------------------------------------------------
// bucket priority queue assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef BUCKET_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BUCKET_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
`define BPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/bpq_pkg.sv =====
// ---------------------------------------------------------------------------
// bpq_pkg
// shared constants, codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package bpq_pkg;

	localparam int CAPACITY   = 1024;
	localparam int KEY_LEVELS = 256;
	localparam int ENTRY_BITS = 32;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int KEY_W  = $clog2(KEY_LEVELS);
	localparam int CNT_W  = $clog2(CAPACITY) + 1;
	localparam int GRP_W  = KEY_W / 2;
	localparam int GRP_N  = 1 << GRP_W;
	localparam int GRP_SZ = KEY_LEVELS / GRP_N;
	localparam int IDX_W  = KEY_W - GRP_W;

	localparam int IN_W  = KEY_W + ENTRY_BITS;
	localparam int OUT_RAW_W = ENTRY_BITS + KEY_W + 2 * CNT_W;
	localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic rd_ins;
		logic rd_rem;
		logic rd2_rem;
		logic wr_ins;
		logic wr_tail;
		logic wr_rem;
		logic scan1;
		logic scan2;
		logic cnt_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic low_none;
		logic need_tail;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/bpq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bpq_ctrl
// operation sequencer: steps inserts and removes through read and write, and every beat through scan and output
// ---------------------------------------------------------------------------
module bpq_ctrl import bpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_kind,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_RD2   = 9'b000000100,
		S_WR1   = 9'b000001000,
		S_WR2   = 9'b000010000,
		S_SCAN1 = 9'b000100000,
		S_SCAN2 = 9'b001000000,
		S_CNT   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   rem_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					cmd.clr  = (in_kind == KIND_CLEAR);
					if (in_kind == KIND_INSERT && !sts.full)
						state_d = S_RD;
					else if (in_kind == KIND_REMOVE && !sts.low_none)
						state_d = S_RD;
					else
						state_d = S_SCAN1;
				end
			end
			S_RD: begin
				cmd.rd_ins = !rem_q;
				cmd.rd_rem = rem_q;
				state_d    = rem_q ? S_RD2 : S_WR1;
			end
			S_RD2: begin
				cmd.rd2_rem = 1'b1;
				state_d     = S_WR1;
			end
			S_WR1: begin
				cmd.wr_ins = !rem_q;
				cmd.wr_rem = rem_q;
				state_d    = (!rem_q && sts.need_tail) ? S_WR2 : S_SCAN1;
			end
			S_WR2: begin
				cmd.wr_tail = 1'b1;
				state_d     = S_SCAN1;
			end
			S_SCAN1: begin
				cmd.scan1 = 1'b1;
				state_d   = S_SCAN2;
			end
			S_SCAN2: begin
				cmd.scan2 = 1'b1;
				state_d   = S_CNT;
			end
			S_CNT: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rem_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				rem_q <= (in_kind == KIND_REMOVE);
		end
	end

endmodule

// ===== rtl/core/bpq_dp.sv =====
// ---------------------------------------------------------------------------
// bpq_dp
// bucket lists, slot store, occupancy scan and result register
// ---------------------------------------------------------------------------
`include "bucket_priority_queue_core_defines.svh"

module bpq_dp import bpq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic [1:0]            in_kind,
	input  logic [KEY_W-1:0]      in_key,
	input  logic [ENTRY_BITS-1:0] in_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_W-1:0]      out_data,
	output logic [1:0]            out_status
);

	logic [ENTRY_BITS-1:0] entry_mem [CAPACITY];
	logic [SLOT_W-1:0]     link_mem  [CAPACITY];
	logic [SLOT_W-1:0]     head_mem  [KEY_LEVELS];
	logic [SLOT_W-1:0]     tail_mem  [KEY_LEVELS];
	logic [CNT_W-1:0]      cnt_mem   [KEY_LEVELS];

	logic [ENTRY_BITS-1:0] entry_rd;
	logic [SLOT_W-1:0]     link_rd, head_rd, tail_rd;
	logic [CNT_W-1:0]      cnt_rd;

	logic                  lifo_q;
	logic [KEY_W-1:0]      key_q;
	logic [ENTRY_BITS-1:0] entry_q;
	status_t               st_q;
	logic [KEY_LEVELS-1:0] ne_q;
	logic [SLOT_W-1:0]     free_head_q, slot_q, tail_q;
	logic [CNT_W-1:0]      fresh_q, held_q;
	logic [KEY_W-1:0]      low_q;
	logic                  low_none_q;
	logic [ENTRY_BITS-1:0] entry_out_q;
	logic [KEY_W-1:0]      key_out_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic [1:0]            out_status_q;

	logic [GRP_N-1:0]      grp_any_s1;
	logic [IDX_W-1:0]      grp_idx_s1 [GRP_N];
	logic [GRP_N-1:0]      grp_any;
	logic [IDX_W-1:0]      grp_idx [GRP_N];
	logic [GRP_W-1:0]      pick_grp;
	logic                  pick_any;

	logic                  use_free, key_ne;
	logic [SLOT_W-1:0]     ins_slot;
	logic [KEY_W-1:0]      rd_addr;
	logic                  rd_bkt_en;
	logic                  link_we, head_we, tail_we, cnt_we;
	logic [SLOT_W-1:0]     link_wa, link_wd, head_wd;
	logic [KEY_W-1:0]      bkt_wa;
	logic [CNT_W-1:0]      cnt_wd;
	logic [CNT_W-1:0]      min_cnt;

	assign use_free = (fresh_q > held_q);
	assign ins_slot = use_free ? free_head_q : fresh_q[SLOT_W-1:0];
	assign key_ne   = ne_q[key_q];
	assign rd_addr  = cmd.rd_ins ? key_q : low_q;
	assign rd_bkt_en = cmd.rd_ins || cmd.rd_rem || cmd.cnt_rd;

	assign sts.full      = (held_q == CNT_W'(CAPACITY));
	assign sts.low_none  = low_none_q;
	assign sts.need_tail = key_ne && !lifo_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	// write port selection
	always_comb begin
		link_we = 1'b0;
		link_wa = ins_slot;
		link_wd = '0;
		head_we = 1'b0;
		tail_we = 1'b0;
		cnt_we  = 1'b0;
		bkt_wa  = key_q;
		head_wd = ins_slot;
		cnt_wd  = CNT_W'(1);
		priority if (cmd.wr_ins) begin
			link_we = 1'b1;
			link_wd = (key_ne && lifo_q) ? head_rd : '0;
			head_we = !key_ne || lifo_q;
			tail_we = !key_ne || !lifo_q;
			cnt_we  = 1'b1;
			cnt_wd  = key_ne ? cnt_rd + CNT_W'(1) : CNT_W'(1);
		end else if (cmd.wr_tail) begin
			link_we = 1'b1;
			link_wa = tail_q;
			link_wd = slot_q;
		end else if (cmd.wr_rem) begin
			link_we = 1'b1;
			link_wa = head_rd;
			link_wd = free_head_q;
			head_we = 1'b1;
			head_wd = link_rd;
			cnt_we  = 1'b1;
			cnt_wd  = cnt_rd - CNT_W'(1);
			bkt_wa  = low_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_ins)
			entry_mem[ins_slot] <= entry_q;
		if (cmd.rd2_rem)
			entry_rd <= entry_mem[head_rd];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (cmd.rd_ins || cmd.rd2_rem)
			link_rd <= link_mem[cmd.rd2_rem ? head_rd : free_head_q];
	end

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[bkt_wa] <= head_wd;
		if (rd_bkt_en)
			head_rd <= head_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (tail_we)
			tail_mem[key_q] <= ins_slot;
		if (cmd.rd_ins)
			tail_rd <= tail_mem[key_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[bkt_wa] <= cnt_wd;
		if (rd_bkt_en)
			cnt_rd <= cnt_mem[rd_addr];
	end

	// occupancy scan, first level per group
	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_any[g] = |ne_q[g*GRP_SZ +: GRP_SZ];
			grp_idx[g] = '0;
			for (int j = GRP_SZ - 1; j >= 0; j--) begin
				if (ne_q[g*GRP_SZ + j])
					grp_idx[g] = IDX_W'(j);
			end
		end
	end

	always_comb begin
		pick_grp = '0;
		pick_any = |grp_any_s1;
		for (int g = GRP_N - 1; g >= 0; g--) begin
			if (grp_any_s1[g])
				pick_grp = GRP_W'(g);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan1) begin
			grp_any_s1 <= grp_any;
			for (int g = 0; g < GRP_N; g++)
				grp_idx_s1[g] <= grp_idx[g];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= in_key;
			entry_q <= in_entry;
		end
		if (cmd.wr_ins) begin
			slot_q <= ins_slot;
			tail_q <= tail_rd;
		end
	end

	assign min_cnt = low_none_q ? '0 : cnt_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifo_q       <= 1'b0;
			st_q         <= ST_OK;
			ne_q         <= '0;
			free_head_q  <= '0;
			fresh_q      <= '0;
			held_q       <= '0;
			low_q        <= '0;
			low_none_q   <= 1'b1;
			entry_out_q  <= '0;
			key_out_q    <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_status_q <= '0;
		end else begin
			if (cfg_we)
				lifo_q <= cfg_wdata;
			if (cmd.load) begin
				entry_out_q <= '0;
				key_out_q   <= '0;
				if (in_kind == KIND_INSERT && sts.full)
					st_q <= ST_FULL;
				else if (in_kind == KIND_REMOVE && low_none_q)
					st_q <= ST_EMPTY;
				else
					st_q <= ST_OK;
			end
			if (cmd.clr) begin
				ne_q        <= '0;
				free_head_q <= '0;
				fresh_q     <= '0;
				held_q      <= '0;
			end
			if (cmd.wr_ins) begin
				ne_q[key_q] <= 1'b1;
				if (use_free)
					free_head_q <= link_rd;
				else
					fresh_q <= fresh_q + CNT_W'(1);
				held_q <= held_q + CNT_W'(1);
			end
			if (cmd.wr_rem) begin
				if (cnt_rd == CNT_W'(1))
					ne_q[low_q] <= 1'b0;
				free_head_q <= head_rd;
				held_q      <= held_q - CNT_W'(1);
				entry_out_q <= entry_rd;
				key_out_q   <= low_q;
			end
			if (cmd.scan2) begin
				low_q      <= {pick_grp, grp_idx_s1[pick_grp]};
				low_none_q <= !pick_any;
			end
			if (cmd.out_load) begin
				out_valid_q  <= 1'b1;
				out_data_q   <= OUT_W'({min_cnt, held_q, key_out_q, entry_out_q});
				out_status_q <= st_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;

	`BPQ_ASSERT_ALWAYS(a_held_cap, clk, held_q <= CNT_W'(CAPACITY), "held count above capacity")
	`BPQ_ASSERT_ALWAYS(a_fresh_held, clk, fresh_q >= held_q, "fresh slot count below held count")
	`BPQ_ASSERT(a_clr_empty, clk, arst_n, cmd.clr |=> (held_q == '0 && ne_q == '0), "clear left entries")
	`BPQ_ASSERT(a_empty_flag, clk, arst_n, (cmd.scan2 && held_q == '0) |=> low_none_q, "empty queue shows a bucket")

endmodule

// ===== rtl/core/bucket_priority_queue_core.sv =====
// ---------------------------------------------------------------------------
// bucket_priority_queue_core
// bucketed priority queue with fifo or lifo ties within a key
// ---------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   tuser: kind[1:0]; tdata: key[7:0], entry[39:8]
// m_axis    out  tuser: status[1:0]; tdata: entry_out, key_out, total, min count
// cfg       in   cfg_we / cfg_wdata: newest_first
//
// an insert reads, writes, scans and outputs, plus a tail link write when fifo
// ties meet a non-empty bucket; a remove reads twice; clear and rejected beats
// only scan and output; an output stall holds any beat. the steps follow the
// registered link and bucket ram reads and the two-stage occupancy scan. reset
// is asynchronous and empties the queue; new beats wait for the output register.
// ---------------------------------------------------------------------------
module bucket_priority_queue_core import bpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // key, entry
	input  logic [1:0]       s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // entry_out, key_out, total_count, min_bucket_count
	output logic [1:0]       m_tuser    // status
);

	cmd_t cmd;
	sts_t sts;

	bpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_kind    (s_tuser),
		.in_key     (s_tdata[KEY_W-1:0]),
		.in_entry   (s_tdata[IN_W-1:KEY_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// bucket priority queue core testbench
// drives insert, remove-min, clear and unused operations through the stream
// ports under both tie orders and checks every result beat against an
// in-bench queue model, with random idling on both sides
// ---------------------------------------------------------------------------
module testbench import bpq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int EXP_DEPTH = 4096;

	typedef struct {
		logic [31:0] entry;
		logic [7:0]  key;
		logic [1:0]  status;
		logic [10:0] total;
		logic [10:0] min_count;
	} pq_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // key[7:0], entry[39:8]
	logic [1:0]       s_tuser;   // kind
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // entry_out, key_out, total_count, min_bucket_count
	logic [1:0]       m_tuser;   // status

	bucket_priority_queue_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// queue model
	logic [31:0] slot_entry [CAPACITY];
	logic [9:0]  slot_link [CAPACITY];
	logic [9:0]  bkt_head [KEY_LEVELS];
	logic [9:0]  bkt_tail [KEY_LEVELS];
	logic [10:0] bkt_size [KEY_LEVELS];
	bit          bkt_used [KEY_LEVELS];
	int          free_head;
	int          fresh_slots;
	int          held;
	bit          lifo_ties;

	pq_result_t  exp_buf [EXP_DEPTH];
	int          exp_wr;
	int          exp_rd;
	int          errors;
	bit          quiet;
	int          stall_req;

	function automatic int lowest_key();
		for (int k = 0; k < KEY_LEVELS; k++)
			if (bkt_used[k])
				return k;
		return KEY_LEVELS;
	endfunction

	function automatic void model_clear();
		for (int k = 0; k < KEY_LEVELS; k++)
			bkt_used[k] = 0;
		free_head = 0;
		fresh_slots = 0;
		held = 0;
	endfunction

	function automatic pq_result_t queue_apply(logic [1:0] kind, logic [7:0] key,
			logic [31:0] entry);
		pq_result_t r;
		int slot;
		int low;
		r = '{entry: '0, key: '0, status: ST_OK, total: '0, min_count: '0};
		if (kind == KIND_INSERT) begin
			if (held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				if (fresh_slots > held) begin
					slot = free_head;
					free_head = slot_link[slot];
				end else begin
					slot = fresh_slots;
					fresh_slots++;
				end
				slot_entry[slot] = entry;
				slot_link[slot] = '0;
				if (!bkt_used[key]) begin
					bkt_head[key] = slot;
					bkt_tail[key] = slot;
					bkt_size[key] = 1;
					bkt_used[key] = 1;
				end else begin
					if (lifo_ties) begin
						slot_link[slot] = bkt_head[key];
						bkt_head[key] = slot;
					end else begin
						slot_link[bkt_tail[key]] = slot;
						bkt_tail[key] = slot;
					end
					bkt_size[key]++;
				end
				held++;
			end
		end else if (kind == KIND_REMOVE) begin
			low = lowest_key();
			if (low >= KEY_LEVELS || held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				slot = bkt_head[low];
				r.entry = slot_entry[slot];
				r.key = low;
				bkt_head[low] = slot_link[slot];
				bkt_size[low]--;
				if (bkt_size[low] == 0)
					bkt_used[low] = 0;
				slot_link[slot] = free_head;
				free_head = slot;
				held--;
			end
		end else if (kind == KIND_CLEAR) begin
			model_clear();
		end
		low = lowest_key();
		r.total = held;
		r.min_count = (low < KEY_LEVELS) ? bkt_size[low] : 11'd0;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// sink side: random back-pressure, plus long hold-offs on request
	initial begin
		int w;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (stall_req > 0) begin
				m_tready <= 0;
				repeat (stall_req) @(posedge clk);
				stall_req = 0;
			end
			w = quiet ? 0 : $urandom_range(0, 10);
			if (w > 0) begin
				m_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pq_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result beat %h / %h", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_r = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (m_tdata[31:0] !== exp_r.entry) begin
					$display("%0t: entry_out expected %h actual %h", $time, exp_r.entry,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[39:32] !== exp_r.key) begin
					$display("%0t: key_out expected %0d actual %0d", $time, exp_r.key,
						m_tdata[39:32]);
					errors++;
				end
				if (m_tuser !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
						m_tuser);
					errors++;
				end
				if (m_tdata[50:40] !== exp_r.total) begin
					$display("%0t: total_count expected %0d actual %0d", $time, exp_r.total,
						m_tdata[50:40]);
					errors++;
				end
				if (m_tdata[61:51] !== exp_r.min_count) begin
					$display("%0t: min_bucket_count expected %0d actual %0d", $time,
						exp_r.min_count, m_tdata[61:51]);
					errors++;
				end
			end
		end
	end

	task automatic send_op(logic [1:0] kind, logic [7:0] key, logic [31:0] entry);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {entry, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		exp_buf[exp_wr % EXP_DEPTH] = queue_apply(kind, key, entry);
		exp_wr++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_tie_order(bit lifo);
		drain();
		cfg_we <= 1;
		cfg_wdata <= lifo;
		@(posedge clk);
		cfg_we <= 0;
		lifo_ties = lifo;
	endtask

	task automatic test_directed();
		send_op(KIND_REMOVE, 8'hff, 32'hffffffff);
		send_op(KIND_INSERT, 8'd255, 32'hffffffff);
		send_op(KIND_INSERT, 8'd0, 32'h00000000);
		send_op(KIND_INSERT, 8'd7, 32'haaaa5555);
		send_op(KIND_INSERT, 8'd7, 32'h5555aaaa);
		send_op(KIND_INSERT, 8'd7, 32'h12345678);
		send_op(KIND_NONE, 8'd3, 32'hdeadbeef);
		repeat (5) send_op(KIND_REMOVE, 8'h00, 32'h0);
		send_op(KIND_INSERT, 8'd9, 32'h0badf00d);
		send_op(KIND_CLEAR, 8'hff, 32'hffffffff);
		send_op(KIND_REMOVE, 8'h00, 32'h0);
		set_tie_order(1);
		send_op(KIND_INSERT, 8'd7, 32'h11111111);
		send_op(KIND_INSERT, 8'd7, 32'h22222222);
		send_op(KIND_INSERT, 8'd7, 32'h33333333);
		send_op(KIND_INSERT, 8'd128, 32'h80000001);
		repeat (4) send_op(KIND_REMOVE, 8'h00, 32'h0);
		set_tie_order(0);
	endtask

	task automatic test_full_store();
		quiet = 1;
		send_op(KIND_CLEAR, 8'd0, 32'd0);
		for (int i = 0; i < CAPACITY; i++)
			send_op(KIND_INSERT, $urandom_range(0, 255), $urandom);
		send_op(KIND_INSERT, 8'd0, $urandom);
		quiet = 0;
		repeat (40) send_op(KIND_REMOVE, 8'd0, 32'd0);
		repeat (40) send_op(KIND_INSERT, $urandom_range(0, 255), $urandom);
		send_op(KIND_INSERT, 8'd1, $urandom);
		send_op(KIND_CLEAR, 8'd0, 32'd0);
	endtask

	task automatic test_random(int count, bit lifo, bit with_stall);
		int r;
		logic [1:0] kind;
		logic [7:0] key;
		set_tie_order(lifo);
		for (int i = 0; i < count; i++) begin
			if (with_stall && i == count / 2)
				stall_req = 300;
			quiet = (i % 200) > 150;
			r = $urandom_range(0, 127);
			if (r < 64)
				kind = KIND_INSERT;
			else if (r < 122)
				kind = KIND_REMOVE;
			else if (r < 125)
				kind = KIND_NONE;
			else
				kind = KIND_CLEAR;
			key = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
			send_op(kind, key, $urandom);
		end
		quiet = 0;
	endtask

	initial begin
		errors = 0;
		exp_wr = 0;
		exp_rd = 0;
		quiet = 0;
		stall_req = 0;
		lifo_ties = 0;
		model_clear();
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = KIND_INSERT;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random(200, 0, 1);
		test_random(150, 1, 0);
		test_random(120, 0, 0);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== bucket_priority_queue_core.f =====
+incdir+rtl/core
rtl/core/bpq_pkg.sv
rtl/core/bpq_ctrl.sv
rtl/core/bpq_dp.sv
rtl/core/bucket_priority_queue_core.sv
tb/testbench.sv
